/* rtl/core/word_frame_receiver_crc16_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the framed word receiver
// Shared property forms used by the port-level checker.
// ----------------------------------------------------------------------------
`ifndef WORD_FRAME_RECEIVER_CRC16_ASSERT_SVH
`define WORD_FRAME_RECEIVER_CRC16_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define WFR_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define WFR_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/wfr_pkg.sv */
// ----------------------------------------------------------------------------
// Framed word receiver package
// Constants, codes, the CRC byte step and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package wfr_pkg;

  localparam int HEADER_LEN = 10;
  localparam int WORD_W     = 16;
  localparam int FILL_W     = 4;
  localparam int CNT_W      = 5;
  localparam int SHIFT_W    = 4;

  // Header CRC covers all words but the last, two bytes each
  localparam int HCRC_BYTES = 2 * (HEADER_LEN - 1);

  localparam logic [WORD_W-1:0] CRC_INIT = 16'hFFFF;
  localparam logic [WORD_W-1:0] CRC_POLY = 16'h1021;
  localparam logic [WORD_W-1:0] MAX_LEN_RESET = 16'd256;

  // Header word positions
  localparam int HW_VERSION = 2;
  localparam int HW_TYPE    = 3;
  localparam int HW_CMD     = 4;
  localparam int HW_SEQ     = 5;
  localparam int HW_FLAGS   = 6;
  localparam int HW_STATUS  = 7;
  localparam int HW_LEN     = 8;
  localparam int HW_CRC     = 9;

  // Configuration register indexes
  localparam logic [1:0] REG_SYNC_FIRST  = 2'd0;
  localparam logic [1:0] REG_SYNC_SECOND = 2'd1;
  localparam logic [1:0] REG_MAX_LEN     = 2'd2;

  // Result event codes
  localparam logic [1:0] EV_HEADER = 2'd0;
  localparam logic [1:0] EV_DATA   = 2'd1;
  localparam logic [1:0] EV_OK     = 2'd2;
  localparam logic [1:0] EV_BAD    = 2'd3;

  // Receive phases
  localparam logic [1:0] PH_HUNT    = 2'd0;
  localparam logic [1:0] PH_PAYLOAD = 2'd1;
  localparam logic [1:0] PH_CHECK   = 2'd2;

  typedef enum logic [1:0] {
    EMIT_HEADER,
    EMIT_DATA,
    EMIT_END
  } wfr_emit_e;

  // Controller commands to the datapath
  typedef struct packed {
    logic      capture;
    logic      hunt;
    logic      pcrc_step;
    logic      pcrc_hi;
    logic      hcrc_step;
    logic      resync;
    logic      shift;
    logic      load;
    wfr_emit_e emit;
  } wfr_cmd_t;

  // Datapath status to the controller
  typedef struct packed {
    logic [1:0] phase;
    logic       hdr_complete;
    logic       hcrc_last;
    logic       hdr_good;
    logic       shift_busy;
    logic       out_free;
  } wfr_status_t;

  // One byte of CRC-16 (poly 0x1021, MSB first)
  function automatic logic [WORD_W-1:0] crc_byte(input logic [WORD_W-1:0] crc,
                                                 input logic [7:0] b);
    logic [WORD_W-1:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[WORD_W-1]) begin
        c = {c[WORD_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[WORD_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

/* rtl/core/word_frame_receiver_crc16.sv */
// ----------------------------------------------------------------------------
// Framed word receiver with CRC-16 header and payload checking
// Top level: joins the controller and the datapath.
// ----------------------------------------------------------------------------
// Items are taken one at a time. A word seen while hunting or collecting the
// header is captured and dispatched; a payload word is captured, dispatched,
// put through two byte steps of the CRC unit and loaded as a result; the
// end-of-frame word is captured, dispatched and loaded as a result. The tenth
// header word adds the 18-byte header CRC, one byte per cycle through the
// single CRC byte unit, and a check step; an accepted header then loads its
// result, while a rejected header shifts the store down one word at a time,
// up to 8 words, as the store realigns on a later sync pair. The result
// register lets the next word in while a result waits; a result that finds it
// still full waits there. Configuration writes are taken every cycle.
module word_frame_receiver_crc16 (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] in_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  event_kind_o,
  output logic [15:0] data_word_o,
  output logic [15:0] proto_version_o,
  output logic [15:0] pkt_type_o,
  output logic [15:0] cmd_code_o,
  output logic [15:0] seq_number_o,
  output logic [15:0] flag_bits_o,
  output logic [15:0] status_word_o,
  output logic [15:0] payload_len_o
);
  import wfr_pkg::*;

  wfr_cmd_t    cmd;
  wfr_status_t st;

  // Registers accept writes at any time
  assign cfg_ready_o = 1'b1;

  wfr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  wfr_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_word_i       (in_word_i),
    .out_stall_i     (out_stall_i),
    .cmd_i           (cmd),
    .st_o            (st),
    .out_valid_o     (out_valid_o),
    .event_kind_o    (event_kind_o),
    .data_word_o     (data_word_o),
    .proto_version_o (proto_version_o),
    .pkt_type_o      (pkt_type_o),
    .cmd_code_o      (cmd_code_o),
    .seq_number_o    (seq_number_o),
    .flag_bits_o     (flag_bits_o),
    .status_word_o   (status_word_o),
    .payload_len_o   (payload_len_o)
  );

endmodule

/* rtl/core/wfr_ctrl.sv */
// ----------------------------------------------------------------------------
// Framed word receiver controller
// Sequences capture, hunt, CRC steps, header check, resync shift and emit.
// ----------------------------------------------------------------------------
module wfr_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  wfr_pkg::wfr_status_t st_i,
  output wfr_pkg::wfr_cmd_t    cmd_o
);
  import wfr_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DISPATCH = 3'd1;
  localparam logic [2:0] S_PCRC_LO  = 3'd2;
  localparam logic [2:0] S_PCRC_HI  = 3'd3;
  localparam logic [2:0] S_HCRC     = 3'd4;
  localparam logic [2:0] S_HCHK     = 3'd5;
  localparam logic [2:0] S_SHIFT    = 3'd6;
  localparam logic [2:0] S_EMIT     = 3'd7;

  logic [2:0] state_q, state_d;
  wfr_emit_e  emit_q, emit_d;

  // Take a new item only when the sequencer is at rest
  assign in_stall_o = (state_q != S_IDLE);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    emit_d  = emit_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (st_i.phase)
          PH_PAYLOAD: state_d = S_PCRC_LO;
          PH_CHECK: begin
            emit_d  = EMIT_END;
            state_d = S_EMIT;
          end
          default: begin
            cmd_o.hunt = 1'b1;
            state_d    = st_i.hdr_complete ? S_HCRC : S_IDLE;
          end
        endcase
      end
      S_PCRC_LO: begin
        cmd_o.pcrc_step = 1'b1;
        state_d         = S_PCRC_HI;
      end
      S_PCRC_HI: begin
        cmd_o.pcrc_step = 1'b1;
        cmd_o.pcrc_hi   = 1'b1;
        emit_d          = EMIT_DATA;
        state_d         = S_EMIT;
      end
      S_HCRC: begin
        cmd_o.hcrc_step = 1'b1;
        if (st_i.hcrc_last) begin
          state_d = S_HCHK;
        end
      end
      S_HCHK: begin
        if (st_i.hdr_good) begin
          emit_d  = EMIT_HEADER;
          state_d = S_EMIT;
        end else begin
          cmd_o.resync = 1'b1;
          state_d      = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (st_i.shift_busy) begin
          cmd_o.shift = 1'b1;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_EMIT: begin
        cmd_o.emit = emit_q;
        if (st_i.out_free) begin
          cmd_o.load = 1'b1;
          state_d    = S_IDLE;
        end
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      emit_q  <= EMIT_HEADER;
    end else begin
      state_q <= state_d;
      emit_q  <= emit_d;
    end
  end

endmodule

/* rtl/core/wfr_dp.sv */
// ----------------------------------------------------------------------------
// Framed word receiver datapath
// Config registers, header store, shared CRC byte unit and result register.
// ----------------------------------------------------------------------------
module wfr_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic [1:0]           cfg_index_i,
  input  logic [15:0]          cfg_data_i,
  input  logic [15:0]          in_word_i,
  input  logic                 out_stall_i,
  input  wfr_pkg::wfr_cmd_t    cmd_i,
  output wfr_pkg::wfr_status_t st_o,
  output logic                 out_valid_o,
  output logic [1:0]           event_kind_o,
  output logic [15:0]          data_word_o,
  output logic [15:0]          proto_version_o,
  output logic [15:0]          pkt_type_o,
  output logic [15:0]          cmd_code_o,
  output logic [15:0]          seq_number_o,
  output logic [15:0]          flag_bits_o,
  output logic [15:0]          status_word_o,
  output logic [15:0]          payload_len_o
);
  import wfr_pkg::*;

  logic [WORD_W-1:0]  sync_first_q, sync_second_q, max_len_q;
  logic [WORD_W-1:0]  store_q [HEADER_LEN];
  logic [FILL_W-1:0]  fill_q, fill_d;
  logic [1:0]         phase_q, phase_d;
  logic [WORD_W-1:0]  left_q, left_d;
  logic [WORD_W-1:0]  crc_q, crc_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [SHIFT_W-1:0] shift_q, shift_d;
  logic [WORD_W-1:0]  word_q;

  logic               out_valid_q;
  logic [1:0]         out_kind_q;
  logic [WORD_W-1:0]  out_data_q, out_ver_q, out_type_q, out_cmd_q;
  logic [WORD_W-1:0]  out_seq_q, out_flags_q, out_status_q, out_len_q;

  logic               store_we;
  logic [FILL_W-1:0]  store_waddr;
  logic [WORD_W-1:0]  store_wdata;
  logic               pair_found;
  logic [SHIFT_W-1:0] pair_pos;
  logic [WORD_W-1:0]  hword;
  logic [7:0]         crc_in;
  logic [WORD_W-1:0]  crc_next;
  logic               out_free;
  logic               is_header, is_data;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_first_q  <= '0;
      sync_second_q <= '0;
      max_len_q     <= MAX_LEN_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_SYNC_FIRST:  sync_first_q  <= cfg_data_i;
        REG_SYNC_SECOND: sync_second_q <= cfg_data_i;
        REG_MAX_LEN:     max_len_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Hold the accepted word for the whole item
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      word_q <= in_word_i;
    end
  end

  // Search the stored words for the lowest later sync pair
  always_comb begin
    pair_found = 1'b0;
    pair_pos   = '0;
    for (int k = HEADER_LEN - 2; k >= 1; k--) begin
      if (store_q[k] == sync_first_q && store_q[k+1] == sync_second_q) begin
        pair_found = 1'b1;
        pair_pos   = SHIFT_W'(k);
      end
    end
  end

  // Shared CRC byte unit: payload word bytes or stored header bytes
  assign hword = store_q[cnt_q[CNT_W-1:1]];
  always_comb begin
    if (cmd_i.hcrc_step) begin
      crc_in = cnt_q[0] ? hword[15:8] : hword[7:0];
    end else begin
      crc_in = cmd_i.pcrc_hi ? word_q[15:8] : word_q[7:0];
    end
  end
  assign crc_next = crc_byte(crc_q, crc_in);

  assign out_free  = !out_valid_q || !out_stall_i;
  assign is_header = cmd_i.load && (cmd_i.emit == EMIT_HEADER);
  assign is_data   = cmd_i.load && (cmd_i.emit == EMIT_DATA);

  // Receive state updates
  always_comb begin
    fill_d      = fill_q;
    phase_d     = phase_q;
    left_d      = left_q;
    crc_d       = crc_q;
    cnt_d       = cnt_q;
    shift_d     = shift_q;
    store_we    = 1'b0;
    store_waddr = fill_q;
    store_wdata = word_q;

    if (cmd_i.hunt) begin
      phase_d = PH_HUNT;
      priority if (fill_q == '0) begin
        if (word_q == sync_first_q) begin
          store_we = 1'b1;
          fill_d   = FILL_W'(1);
        end
      end else if (fill_q == FILL_W'(1)) begin
        if (word_q == sync_second_q) begin
          store_we = 1'b1;
          fill_d   = FILL_W'(2);
        end else if (word_q != sync_first_q) begin
          fill_d = '0;
        end
      end else if (fill_q >= FILL_W'(HEADER_LEN)) begin
        fill_d = '0;
      end else begin
        store_we = 1'b1;
        fill_d   = fill_q + FILL_W'(1);
      end
    end

    if (cmd_i.pcrc_step) begin
      crc_d = crc_next;
    end

    if (cmd_i.hcrc_step) begin
      crc_d = crc_next;
      cnt_d = (cnt_q == CNT_W'(HCRC_BYTES - 1)) ? '0 : cnt_q + CNT_W'(1);
    end

    // Bad header: keep a later sync pair, or a trailing first sync word
    if (cmd_i.resync) begin
      crc_d = CRC_INIT;
      if (pair_found) begin
        shift_d = pair_pos;
        fill_d  = FILL_W'(HEADER_LEN) - FILL_W'(pair_pos);
      end else if (store_q[HW_CRC] == sync_first_q) begin
        store_we    = 1'b1;
        store_waddr = '0;
        store_wdata = sync_first_q;
        fill_d      = FILL_W'(1);
      end else begin
        fill_d = '0;
      end
    end

    if (cmd_i.shift) begin
      shift_d = shift_q - SHIFT_W'(1);
    end

    if (cmd_i.load) begin
      unique case (cmd_i.emit)
        EMIT_HEADER: begin
          left_d  = store_q[HW_LEN];
          crc_d   = CRC_INIT;
          fill_d  = '0;
          phase_d = (store_q[HW_LEN] != '0) ? PH_PAYLOAD : PH_CHECK;
        end
        EMIT_DATA: begin
          left_d = left_q - WORD_W'(1);
          if (left_q == WORD_W'(1)) begin
            phase_d = PH_CHECK;
          end
        end
        EMIT_END: begin
          phase_d = PH_HUNT;
          fill_d  = '0;
          crc_d   = CRC_INIT;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      phase_q <= PH_HUNT;
      left_q  <= '0;
      crc_q   <= CRC_INIT;
      cnt_q   <= '0;
      shift_q <= '0;
    end else begin
      fill_q  <= fill_d;
      phase_q <= phase_d;
      left_q  <= left_d;
      crc_q   <= crc_d;
      cnt_q   <= cnt_d;
      shift_q <= shift_d;
    end
  end

  // Header store: single write port, one-step shift down during resync
  always_ff @(posedge clk_i) begin
    if (cmd_i.shift) begin
      for (int i = 0; i < HEADER_LEN - 1; i++) begin
        store_q[i] <= store_q[i+1];
      end
    end else if (store_we) begin
      store_q[store_waddr] <= store_wdata;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      unique case (cmd_i.emit)
        EMIT_HEADER: out_kind_q <= EV_HEADER;
        EMIT_DATA:   out_kind_q <= EV_DATA;
        EMIT_END:    out_kind_q <= (crc_q == word_q) ? EV_OK : EV_BAD;
        default:     out_kind_q <= EV_BAD;
      endcase
      out_data_q   <= is_data   ? word_q              : '0;
      out_ver_q    <= is_header ? store_q[HW_VERSION] : '0;
      out_type_q   <= is_header ? store_q[HW_TYPE]    : '0;
      out_cmd_q    <= is_header ? store_q[HW_CMD]     : '0;
      out_seq_q    <= is_header ? store_q[HW_SEQ]     : '0;
      out_flags_q  <= is_header ? store_q[HW_FLAGS]   : '0;
      out_status_q <= is_header ? store_q[HW_STATUS]  : '0;
      out_len_q    <= is_header ? store_q[HW_LEN]     : '0;
    end
  end

  // Status to the controller
  assign st_o.phase        = phase_q;
  assign st_o.hdr_complete = (fill_q == FILL_W'(HEADER_LEN - 1));
  assign st_o.hcrc_last    = (cnt_q == CNT_W'(HCRC_BYTES - 1));
  assign st_o.hdr_good     = (crc_q == store_q[HW_CRC]) && (store_q[HW_LEN] <= max_len_q);
  assign st_o.shift_busy   = (shift_q != '0);
  assign st_o.out_free     = out_free;

  assign out_valid_o     = out_valid_q;
  assign event_kind_o    = out_kind_q;
  assign data_word_o     = out_data_q;
  assign proto_version_o = out_ver_q;
  assign pkt_type_o      = out_type_q;
  assign cmd_code_o      = out_cmd_q;
  assign seq_number_o    = out_seq_q;
  assign flag_bits_o     = out_flags_q;
  assign status_word_o   = out_status_q;
  assign payload_len_o   = out_len_q;

endmodule

/* rtl/core/wfr_checker.sv */
// ----------------------------------------------------------------------------
// Framed word receiver port checker
// Watches the result port over time; bound onto the top level.
// ----------------------------------------------------------------------------
`include "word_frame_receiver_crc16_assert.svh"

module wfr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  event_kind_o,
  input logic [15:0] data_word_o,
  input logic [15:0] proto_version_o,
  input logic [15:0] payload_len_o
);
  import wfr_pkg::*;

  // A stalled result stays offered
  `WFR_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o, "result dropped while stalled")

  // A stalled result keeps its event code
  `WFR_ASSERT_NEXT(a_kind_hold, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(event_kind_o), "event code changed while stalled")

  // Only payload events carry a data word
  `WFR_ASSERT_SAME(a_data_zero, clk_i, rst_ni, out_valid_o && event_kind_o != EV_DATA, data_word_o == 16'd0, "data word set on a non-payload event")

  // Only header events carry header fields
  `WFR_ASSERT_SAME(a_hdr_zero, clk_i, rst_ni, out_valid_o && event_kind_o != EV_HEADER, proto_version_o == 16'd0 && payload_len_o == 16'd0, "header fields set on a non-header event")

endmodule

bind word_frame_receiver_crc16 wfr_checker u_wfr_checker (.*);

/* tb/word_frame_receiver_crc16_test.sv */
// ----------------------------------------------------------------------------
// Framed word receiver testbench
// Drives word streams into the receiver, a short table of hand-built frames
// first and then random frames, broken headers and noise under several sync
// and length settings. A built-in frame model predicts every event, and the
// checker compares each event the block hands out against the oldest one
// predicted.
// ----------------------------------------------------------------------------
module word_frame_receiver_crc16_test;
  timeunit 1ns;
  timeprecision 1ps;

  import wfr_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 64;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_WORDS  = 125;
  localparam int REPORT_MAX   = 10;

  // One event as it appears on the result ports
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] data;
    logic [15:0] version;
    logic [15:0] ptype;
    logic [15:0] cmd;
    logic [15:0] seq;
    logic [15:0] flags;
    logic [15:0] status;
    logic [15:0] len;
  } frame_event_t;

  // Where a hand-built word comes from
  typedef enum logic [2:0] {
    SRC_LIT,
    SRC_SYNC1,
    SRC_SYNC2,
    SRC_HCRC,
    SRC_HCRC_BAD,
    SRC_PCRC,
    SRC_PCRC_BAD
  } word_src_e;

  // How the event of a word is obtained
  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_QUIET,
    CHK_OK,
    CHK_BAD
  } word_check_e;

  typedef struct packed {
    word_src_e   src;
    logic [15:0] lit;
    word_check_e chk;
  } directed_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = REG_SYNC_FIRST;
  logic [15:0] cfg_data_i = 16'h0000;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [15:0] in_word_i = 16'h0000;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  event_kind_o;
  logic [15:0] data_word_o;
  logic [15:0] proto_version_o;
  logic [15:0] pkt_type_o;
  logic [15:0] cmd_code_o;
  logic [15:0] seq_number_o;
  logic [15:0] flag_bits_o;
  logic [15:0] status_word_o;
  logic [15:0] payload_len_o;

  // Frame model state and its copy of the registers
  logic [15:0] p_sync1 = 16'h0000;
  logic [15:0] p_sync2 = 16'h0000;
  logic [15:0] p_max = MAX_LEN_RESET;
  logic [15:0] p_store [HEADER_LEN];
  int          p_fill = 0;
  logic [1:0]  p_phase = PH_HUNT;
  logic [15:0] p_left = 16'h0000;
  logic [15:0] p_pcrc = CRC_INIT;

  frame_event_t pending_events[$];
  int           mismatches = 0;
  int           words_offered = 0;
  int           cycle_count = 0;
  int           send_idle_pct = 0;
  int           recv_idle_pct = 0;
  logic         hold_go = 1'b0;
  logic         hold_done = 1'b0;
  int           hold_left = 0;

  word_frame_receiver_crc16 uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .in_word_i       (in_word_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .event_kind_o    (event_kind_o),
    .data_word_o     (data_word_o),
    .proto_version_o (proto_version_o),
    .pkt_type_o      (pkt_type_o),
    .cmd_code_o      (cmd_code_o),
    .seq_number_o    (seq_number_o),
    .flag_bits_o     (flag_bits_o),
    .status_word_o   (status_word_o),
    .payload_len_o   (payload_len_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Fold one word into a CRC, low byte first, MSB first within a byte
  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [15:0] w);
    logic [15:0] c;
    logic [7:0]  b;
    c = crc;
    for (int k = 0; k < 2; k++) begin
      b = (k == 0) ? w[7:0] : w[15:8];
      c = c ^ {b, 8'h00};
      for (int j = 0; j < 8; j++) begin
        c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  // CRC over the nine header words currently held
  function automatic logic [15:0] held_crc();
    logic [15:0] c;
    c = CRC_INIT;
    for (int i = 0; i < HEADER_LEN - 1; i++) begin
      c = crc_fold(c, p_store[i]);
    end
    return c;
  endfunction

  function automatic logic [15:0] rand_word();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Payload length that the current limit accepts, mostly short
  function automatic logic [15:0] short_len();
    int hi;
    hi = ($urandom_range(0, 9) == 0) ? 24 : 5;
    if (int'(p_max) < hi) begin
      hi = int'(p_max);
    end
    return 16'($urandom_range(0, hi));
  endfunction

  // Search the held words for a later sync pair and shift it down
  task automatic realign_store();
    int n;
    n = 0;
    for (int s = 1; s + 1 < HEADER_LEN; s++) begin
      if (n == 0 && p_store[s] == p_sync1 && p_store[s+1] == p_sync2) begin
        n = HEADER_LEN - s;
        for (int i = 0; i < n; i++) begin
          p_store[i] = p_store[s+i];
        end
      end
    end
    if (n == 0 && p_store[HEADER_LEN-1] == p_sync1) begin
      p_store[0] = p_sync1;
      n = 1;
    end
    p_fill = n;
  endtask

  // Advance the frame model by one word and return the event it causes
  task automatic predict_word(input logic [15:0] w, output bit got, output frame_event_t ev);
    got = 1'b0;
    ev = '0;
    case (p_phase)
      PH_PAYLOAD: begin
        ev.kind = EV_DATA;
        ev.data = w;
        p_pcrc = crc_fold(p_pcrc, w);
        p_left = p_left - 16'd1;
        if (p_left == 16'd0) begin
          p_phase = PH_CHECK;
        end
        got = 1'b1;
      end
      PH_CHECK: begin
        ev.kind = (p_pcrc == w) ? EV_OK : EV_BAD;
        p_phase = PH_HUNT;
        p_fill = 0;
        p_pcrc = CRC_INIT;
        got = 1'b1;
      end
      default: begin
        p_phase = PH_HUNT;
        if (p_fill == 0) begin
          if (w == p_sync1) begin
            p_store[0] = w;
            p_fill = 1;
          end
        end else if (p_fill == 1) begin
          if (w == p_sync2) begin
            p_store[1] = w;
            p_fill = 2;
          end else if (w != p_sync1) begin
            p_fill = 0;
          end
        end else if (p_fill >= HEADER_LEN) begin
          p_fill = 0;
        end else begin
          p_store[p_fill] = w;
          p_fill++;
          if (p_fill == HEADER_LEN) begin
            if (held_crc() != p_store[HW_CRC] || p_store[HW_LEN] > p_max) begin
              realign_store();
            end else begin
              ev.kind = EV_HEADER;
              ev.version = p_store[HW_VERSION];
              ev.ptype = p_store[HW_TYPE];
              ev.cmd = p_store[HW_CMD];
              ev.seq = p_store[HW_SEQ];
              ev.flags = p_store[HW_FLAGS];
              ev.status = p_store[HW_STATUS];
              ev.len = p_store[HW_LEN];
              p_left = p_store[HW_LEN];
              p_pcrc = CRC_INIT;
              p_fill = 0;
              p_phase = (p_left != 16'd0) ? PH_PAYLOAD : PH_CHECK;
              got = 1'b1;
            end
          end
        end
      end
    endcase
  endtask

  // Predict, queue the event, then offer the word until it is taken
  task automatic put_word(input logic [15:0] w, input word_check_e chk);
    bit           got;
    frame_event_t ev;
    predict_word(w, got, ev);
    if (chk == CHK_QUIET) begin
      got = 1'b0;
    end else if (chk != CHK_MODEL) begin
      ev = '0;
      ev.kind = (chk == CHK_OK) ? EV_OK : EV_BAD;
      got = 1'b1;
    end
    if (got) begin
      pending_events.push_back(ev);
    end
    words_offered++;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i <= w;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Fill the header up, then run the payload and its CRC word
  task automatic complete_frame();
    while (p_phase == PH_HUNT && p_fill >= 2 && p_fill < HEADER_LEN - 1) begin
      put_word((p_fill == HW_LEN) ? short_len() : rand_word(), CHK_MODEL);
    end
    if (p_phase == PH_HUNT && p_fill == HEADER_LEN - 1) begin
      put_word((p_store[HW_LEN] <= 16'd24) ? held_crc() : ~held_crc(), CHK_MODEL);
    end
    while (p_phase == PH_PAYLOAD) begin
      put_word(rand_word(), CHK_MODEL);
    end
    if (p_phase == PH_CHECK) begin
      put_word(($urandom_range(0, 4) != 0) ? p_pcrc
               : (p_pcrc ^ 16'($urandom_range(1, 65535))), CHK_MODEL);
    end
  endtask

  // One random frame, broken header or stretch of noise
  task automatic random_frame();
    int shape;
    int pos;
    int n;
    shape = $urandom_range(0, 99);
    if (shape < 55) begin
      put_word(p_sync1, CHK_MODEL);
      put_word(p_sync2, CHK_MODEL);
      complete_frame();
    end else if (shape < 65) begin
      // bad header CRC, sometimes with a later sync pair to realign on
      pos = ($urandom_range(0, 1) == 0) ? $urandom_range(2, 7) : 0;
      put_word(p_sync1, CHK_MODEL);
      put_word(p_sync2, CHK_MODEL);
      for (int i = 2; i < HEADER_LEN - 1; i++) begin
        if (pos != 0 && i == pos) begin
          put_word(p_sync1, CHK_MODEL);
        end else if (pos != 0 && i == pos + 1) begin
          put_word(p_sync2, CHK_MODEL);
        end else begin
          put_word((i == HW_LEN) ? short_len() : rand_word(), CHK_MODEL);
        end
      end
      put_word(held_crc() ^ 16'($urandom_range(1, 65535)), CHK_MODEL);
      complete_frame();
    end else if (shape < 72) begin
      // length above the limit with a good CRC
      put_word(p_sync1, CHK_MODEL);
      put_word(p_sync2, CHK_MODEL);
      for (int i = 2; i < HW_LEN; i++) begin
        put_word(rand_word(), CHK_MODEL);
      end
      put_word((p_max < 16'hFFFF) ? 16'($urandom_range(int'(p_max) + 1, 65535))
               : short_len(), CHK_MODEL);
      put_word(held_crc(), CHK_MODEL);
      complete_frame();
    end else if (shape < 78) begin
      // CRC word equal to the first sync word
      put_word(p_sync1, CHK_MODEL);
      put_word(p_sync2, CHK_MODEL);
      for (int i = 2; i < HW_LEN; i++) begin
        put_word(rand_word(), CHK_MODEL);
      end
      put_word(short_len(), CHK_MODEL);
      put_word(p_sync1, CHK_MODEL);
    end else if (shape < 85) begin
      // header cut short
      put_word(p_sync1, CHK_MODEL);
      put_word(p_sync2, CHK_MODEL);
      n = $urandom_range(0, 6);
      for (int i = 0; i < n; i++) begin
        put_word(rand_word(), CHK_MODEL);
      end
    end else if (shape < 92) begin
      // repeated first sync word, then a wrong second word
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++) begin
        put_word(p_sync1, CHK_MODEL);
      end
      put_word(rand_word(), CHK_MODEL);
    end else begin
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) begin
        put_word(rand_word(), CHK_MODEL);
      end
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_SYNC_FIRST:  p_sync1 = val;
      REG_SYNC_SECOND: p_sync2 = val;
      REG_MAX_LEN:     p_max = val;
      default: ;
    endcase
  endtask

  task automatic set_regs(input logic [15:0] first, input logic [15:0] second,
                          input logic [15:0] limit);
    write_reg(REG_SYNC_FIRST, first);
    write_reg(REG_SYNC_SECOND, second);
    write_reg(REG_MAX_LEN, limit);
    cfg_valid_i <= 1'b0;
  endtask

  // Drop valid, wait for every event, then let header work finish
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_events.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic random_words();
    int start;
    start = words_offered;
    while (words_offered - start < PHASE_WORDS) begin
      random_frame();
    end
  endtask

  task automatic report_event(input string why, input frame_event_t want,
                              input frame_event_t seen);
    mismatches++;
    if (mismatches <= REPORT_MAX) begin
      $display("[%0t] %s", $realtime, why);
      $display("  expected kind=%0d data=%h hdr=%h %h %h %h %h %h len=%h",
               want.kind, want.data, want.version, want.ptype, want.cmd,
               want.seq, want.flags, want.status, want.len);
      $display("  actual   kind=%0d data=%h hdr=%h %h %h %h %h %h len=%h",
               seen.kind, seen.data, seen.version, seen.ptype, seen.cmd,
               seen.seq, seen.flags, seen.status, seen.len);
    end
  endtask

  // Hold off the receiver once for a long stretch, else stall at random
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_go && !hold_done) begin
      out_stall_i <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Compare each delivered event with the oldest prediction
  always @(posedge clk_i) begin
    frame_event_t seen;
    frame_event_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen = {event_kind_o, data_word_o, proto_version_o, pkt_type_o, cmd_code_o,
              seq_number_o, flag_bits_o, status_word_o, payload_len_o};
      if (pending_events.size() == 0) begin
        report_event("event with none predicted", '0, seen);
      end else begin
        want = pending_events.pop_front();
        if (seen !== want) begin
          report_event("event mismatch", want, seen);
        end
      end
    end
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    directed_row_t rows [28];
    logic [15:0]   w;
    rows = '{
      '{SRC_SYNC1,    16'h0000, CHK_QUIET},
      '{SRC_SYNC1,    16'h0000, CHK_QUIET},   // repeated first sync keeps hunting
      '{SRC_LIT,      16'hFFFF, CHK_QUIET},   // wrong second word restarts
      '{SRC_SYNC1,    16'h0000, CHK_QUIET},
      '{SRC_SYNC2,    16'h0000, CHK_QUIET},
      '{SRC_SYNC1,    16'h0000, CHK_QUIET},   // later sync pair inside the header
      '{SRC_SYNC2,    16'h0000, CHK_QUIET},
      '{SRC_LIT,      16'hFFFF, CHK_QUIET},
      '{SRC_LIT,      16'h0000, CHK_QUIET},
      '{SRC_LIT,      16'h8001, CHK_QUIET},
      '{SRC_LIT,      16'h7FFE, CHK_QUIET},
      '{SRC_LIT,      16'hFFFF, CHK_QUIET},
      '{SRC_HCRC_BAD, 16'h0000, CHK_QUIET},   // bad CRC: realign on the pair
      '{SRC_LIT,      16'h0001, CHK_QUIET},   // length of the realigned header
      '{SRC_HCRC,     16'h0000, CHK_MODEL},
      '{SRC_LIT,      16'hFFFF, CHK_MODEL},
      '{SRC_PCRC,     16'h0000, CHK_OK},
      '{SRC_SYNC1,    16'h0000, CHK_QUIET},   // empty payload frame
      '{SRC_SYNC2,    16'h0000, CHK_QUIET},
      '{SRC_LIT,      16'h0000, CHK_QUIET},
      '{SRC_LIT,      16'hFFFF, CHK_QUIET},
      '{SRC_LIT,      16'h0000, CHK_QUIET},
      '{SRC_LIT,      16'hFFFF, CHK_QUIET},
      '{SRC_LIT,      16'h0000, CHK_QUIET},
      '{SRC_LIT,      16'hFFFF, CHK_QUIET},
      '{SRC_LIT,      16'h0000, CHK_QUIET},
      '{SRC_HCRC,     16'h0000, CHK_MODEL},
      '{SRC_PCRC_BAD, 16'h0000, CHK_BAD}
    };

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Hand-built frames
    set_regs(16'hA55A, 16'h5AA5, 16'd3);
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    foreach (rows[i]) begin
      case (rows[i].src)
        SRC_SYNC1:    w = p_sync1;
        SRC_SYNC2:    w = p_sync2;
        SRC_HCRC:     w = held_crc();
        SRC_HCRC_BAD: w = held_crc() ^ 16'h0001;
        SRC_PCRC:     w = p_pcrc;
        SRC_PCRC_BAD: w = ~p_pcrc;
        default:      w = rows[i].lit;
      endcase
      put_word(w, rows[i].chk);
    end
    settle();

    // Extreme sync words, no payload allowed; receiver stalls often
    set_regs(16'h0000, 16'hFFFF, 16'd0);
    send_idle_pct = 14;
    recv_idle_pct <= 69;
    random_words();
    settle();

    // Swapped extremes, no length limit; sender idles often
    set_regs(16'hFFFF, 16'h0000, 16'hFFFF);
    send_idle_pct = 69;
    recv_idle_pct <= 14;
    random_words();
    settle();

    // Equal sync words, small limit, full rate with one long receiver hold
    w = 16'($urandom);
    set_regs(w, w, 16'($urandom_range(1, 12)));
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    hold_go <= 1'b1;
    random_words();
    settle();

    // Random sync pair, default limit, full rate
    set_regs(16'($urandom), 16'($urandom), MAX_LEN_RESET);
    random_words();
    settle();

    if (mismatches == 0 && pending_events.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
